>>> design/ocpm_pkg.sv
`timescale 1ns / 1ps
// Package for the oxygen cell percent monitor.
// Holds field widths and fixed constants shared by the monitor unit and the window; no dependencies.

package ocpm_pkg;

   // Field widths of the stream and register ports.
   localparam int SAMPLE_W   = 16;
   localparam int CAL_W      = 16;
   localparam int AVG_W      = 16;
   localparam int TENTHS_W   = 10;
   localparam int RSP_DATA_W = 32;

   // Valid cell window in counts (5 mV and 20 mV at 0.0625 mV per count).
   localparam int CAL_LOW    = 80;
   localparam int CAL_HIGH   = 320;

   // Air holds 20.9 percent oxygen; results saturate at 99.9 percent.
   localparam int AIR_TENTHS = 209;
   localparam int AIR_W      = 8;
   localparam int MAX_TENTHS = 999;

endpackage

>>> design/oxygen_cell_percent_monitor_unit.sv
`timescale 1ns / 1ps
// Oxygen cell monitor: averages cell samples over a moving window and reports
// the mean, the oxygen percentage against air calibration and a warning flag.
// One item is handled at a time. The sequencer first updates the window sum,
// and the oldest sample is read on the transfer edge itself. The ABS and CHK
// states then form the magnitude, the calibration product and the range check.
// The two bit-serial dividers then run side by side, the 16-bit average
// quotient taking longest. The result register is loaded once both have
// finished, and the sequencer returns to idle, where the next sample can
// transfer.
// The result register lets the next sample transfer in while a result still
// waits; a waiting result holds the sequencer only once the following item
// has finished its division. The calibration register resets to zero, which
// holds the warning on until it is written.
// Depends on ocpm_pkg, ocpm_window and ocpm_sdiv.

module oxygen_cell_percent_monitor_unit #(
   parameter int WINDOW_LEN = 40
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ocpm_pkg::SAMPLE_W-1:0]   req_tdata,    // [15:0] sample
   // Result stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ocpm_pkg::RSP_DATA_W-1:0] rsp_tdata,    // [15:0] average_counts,
                                                         // [25:16] oxygen_tenths,
                                                         // [31:26] zero
   output logic [0:0]                      rsp_tuser,    // [0] cell_warning
   // Calibration register write.
   input  logic                            csr_wr_en,
   input  logic [ocpm_pkg::CAL_W-1:0]      csr_wr_data
);

   import ocpm_pkg::*;

   localparam int CNT_W     = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W     = SAMPLE_W + CNT_W;
   localparam int TNUM_W    = SUM_W + AIR_W;
   localparam int PROD_W    = CNT_W + CAL_W;
   localparam int PAD_W     = RSP_DATA_W - AVG_W - TENTHS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPD,
      S_ABS,
      S_CHK,
      S_DIV
   } state_type;

   state_type            state_ff, state_in;
   logic [CAL_W-1:0]     cal_ff;
   logic [SUM_W-1:0]     mag_ff, mag_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 cal_ok_ff, cal_ok_in;
   logic                 warn_ff, warn_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0]     avg_out_ff;
   logic [TENTHS_W-1:0]  tenths_out_ff, tenths_in;
   logic                 warn_out_ff;
   logic                 load_out;

   logic                 req_xfer;
   logic [SUM_W-1:0]     win_sum;
   logic [CNT_W-1:0]     win_fill;
   logic [SUM_W-1:0]     lim_lo, lim_hi;
   logic [TNUM_W-1:0]    tnum;
   logic                 div_start;
   logic                 avg_busy, ten_busy;
   logic [AVG_W-1:0]     avg_q;
   logic [TENTHS_W-1:0]  ten_q;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // Sample ring, running sum and fill count.
   ocpm_window #(
      .WINDOW_LEN (WINDOW_LEN),
      .CNT_W      (CNT_W),
      .SUM_W      (SUM_W)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .load   (req_xfer),
      .sample (req_tdata),
      .sum    (win_sum),
      .fill   (win_fill)
   );

   // Average in counts: magnitude over fill count.
   ocpm_sdiv #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W),
      .QUO_W (AVG_W)
   ) u_avg_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (mag_ff),
      .denom    (cnt_ff),
      .busy     (avg_busy),
      .quotient (avg_q)
   );

   // Oxygen in tenths: magnitude times 20.9 over fill count times calibration.
   // Only its no-warning results are used, where the quotient stays below 826.
   ocpm_sdiv #(
      .NUM_W (TNUM_W),
      .DEN_W (PROD_W),
      .QUO_W (TENTHS_W)
   ) u_ten_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (tnum),
      .denom    (prod_ff),
      .busy     (ten_busy),
      .quotient (ten_q)
   );

   // Magnitude, calibration product and range checks.
   always_comb begin
      mag_in    = win_sum[SUM_W-1] ? SUM_W'(0) - win_sum : win_sum;
      prod_in   = PROD_W'(win_fill) * PROD_W'(cal_ff);
      cal_ok_in = (cal_ff > CAL_W'(CAL_LOW)) && (cal_ff < CAL_W'(CAL_HIGH));
      lim_lo    = SUM_W'(cnt_ff) * SUM_W'(CAL_LOW);
      lim_hi    = SUM_W'(cnt_ff) * SUM_W'(CAL_HIGH);
      warn_in   = !(cal_ok_ff && (mag_ff > lim_lo) && (mag_ff < lim_hi));
      tnum      = TNUM_W'(mag_ff) * TNUM_W'(AIR_TENTHS);
      div_start = (state_ff == S_CHK);
      tenths_in = (ten_q > TENTHS_W'(MAX_TENTHS)) ? TENTHS_W'(MAX_TENTHS) : ten_q;
   end

   // Sequencer and result handoff.
   always_comb begin
      state_in     = state_ff;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            state_in = S_ABS;
         end
         S_ABS: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!avg_busy && !ten_busy && (!rsp_valid_ff || rsp_tready)) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, configuration and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cal_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cal_ff <= csr_wr_data;
         end
      end
      if (state_ff == S_ABS) begin
         mag_ff    <= mag_in;
         cnt_ff    <= win_fill;
         prod_ff   <= prod_in;
         cal_ok_ff <= cal_ok_in;
      end
      if (state_ff == S_CHK) begin
         warn_ff <= warn_in;
      end
      if (load_out) begin
         avg_out_ff    <= avg_q;
         tenths_out_ff <= warn_ff ? '0 : tenths_in;
         warn_out_ff   <= warn_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, tenths_out_ff, avg_out_ff};
   assign rsp_tuser  = warn_out_ff;

   // A warning always forces the oxygen figure to zero.
   a_warn_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[AVG_W +: TENTHS_W] == '0))
      else $error("oxygen figure nonzero under warning");

   // The oxygen figure never passes saturation.
   a_tenths_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[AVG_W +: TENTHS_W] <= TENTHS_W'(MAX_TENTHS)))
      else $error("oxygen figure above saturation");

   // Without a warning the average lies inside the cell window.
   a_avg_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         (rsp_tdata[AVG_W-1:0] >= AVG_W'(CAL_LOW)) &&
         (rsp_tdata[AVG_W-1:0] < AVG_W'(CAL_HIGH)))
      else $error("average outside window without warning");

   // The fill count never exceeds the window length.
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      win_fill <= CNT_W'(WINDOW_LEN))
      else $error("fill count beyond window length");

endmodule

>>> design/ocpm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Used for the sample ring; no package dependency.

module ocpm_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 40,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ocpm_window.sv
`timescale 1ns / 1ps
// Moving window of cell samples: sample ring in RAM, running sum and fill count.
// Depends on ocpm_pkg and ocpm_ram.

module ocpm_window #(
   parameter int WINDOW_LEN = 40,
   parameter int CNT_W      = 6,
   parameter int SUM_W      = 22
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [ocpm_pkg::SAMPLE_W-1:0] sample,
   output logic [SUM_W-1:0]              sum,
   output logic [CNT_W-1:0]              fill
);

   import ocpm_pkg::*;

   localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int EXT_W  = SUM_W - SAMPLE_W;

   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                upd_ff;
   logic [SAMPLE_W-1:0] old_sample;
   logic                full;
   logic [SUM_W-1:0]    new_ext, old_ext;

   // The slot about to be overwritten is read while the sample is taken in,
   // so the oldest sample is ready in the update cycle.
   ocpm_ram #(
      .DATA_W (SAMPLE_W),
      .DEPTH  (WINDOW_LEN),
      .ADDR_W (SLOT_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (upd_ff),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_addr (slot_ff),
      .rd_data (old_sample)
   );

   // Sum update: add the new sample, drop the oldest once the window is full.
   always_comb begin
      full    = (fill_ff == CNT_W'(WINDOW_LEN));
      new_ext = {{EXT_W{sample_ff[SAMPLE_W-1]}}, sample_ff};
      old_ext = full ? {{EXT_W{old_sample[SAMPLE_W-1]}}, old_sample} : '0;
      sum_in  = sum_ff + new_ext - old_ext;
      fill_in = full ? fill_ff : fill_ff + CNT_W'(1);
      slot_in = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + SLOT_W'(1);
   end

   // Window registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         upd_ff  <= 1'b0;
         slot_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else begin
         upd_ff <= load;
         if (upd_ff) begin
            slot_ff <= slot_in;
            fill_ff <= fill_in;
            sum_ff  <= sum_in;
         end
      end
      if (load) begin
         sample_ff <= sample;
      end
   end

   assign sum  = sum_ff;
   assign fill = fill_ff;

endmodule

>>> design/ocpm_sdiv.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle, shifted divisor.
// The caller keeps the numerator below denominator times 2**QUO_W. No package use.

module ocpm_sdiv #(
   parameter int NUM_W = 22,
   parameter int DEN_W = 6,
   parameter int QUO_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic [QUO_W-1:0] quotient
);

   localparam int SH_W  = DEN_W + QUO_W - 1;
   localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [SH_W-1:0]  den_ff, den_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic [CMP_W-1:0] rem_x, den_x, diff;
   logic             ge;

   // One compare and subtract per cycle; the divisor shifts right each step.
   always_comb begin
      rem_x    = CMP_W'(rem_ff);
      den_x    = CMP_W'(den_ff);
      ge       = (rem_x >= den_x);
      diff     = rem_x - den_x;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         rem_in   = numer;
         den_in   = SH_W'(denom) << (QUO_W - 1);
         quo_in   = '0;
         count_in = CNT_W'(QUO_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? NUM_W'(diff) : rem_ff;
         den_in   = den_ff >> 1;
         quo_in   = QUO_W'({quo_ff, ge});
         count_in = count_ff - CNT_W'(1);
         busy_in  = (count_ff != CNT_W'(1));
      end
   end

   // Divider registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule
